[rtl/br90_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// br90_pkg
// Types, codes and helpers for the packed bitmap 90-degree rotator.
// ----------------------------------------------------------------------------
package br90_pkg;

    localparam int MAX_DIM_DEF     = 128;
    localparam int FRAME_BYTES_DEF = 32768;
    localparam int MAX_STRIDE_DEF  = 256;

    // widest linear address: 254 * 511 + 509 fits in 17 bits
    localparam int CALC_W = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_STRIDE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_CW     = 3'd5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_2  = 3'd1;
    localparam logic [2:0] DEPTH_4  = 3'd2;
    localparam logic [2:0] DEPTH_8  = 3'd3;
    localparam logic [2:0] DEPTH_16 = 3'd4;

    typedef struct packed {
        logic       action;
        logic [6:0] row;
        logic [7:0] byte_col;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_of_range;
    } t_out_word;

    // source reads per destination byte; zero for unused depth codes
    function automatic logic [3:0] pixels_per_byte(input logic [2:0] depth);
        logic [3:0] n;
        case (depth)
            DEPTH_1:  n = 4'd8;
            DEPTH_2:  n = 4'd4;
            DEPTH_4:  n = 4'd2;
            DEPTH_8:  n = 4'd1;
            DEPTH_16: n = 4'd1;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

    // top pixel field of a byte after the pixel is shifted to the MSB end
    function automatic logic [7:0] top_mask(input logic [2:0] depth);
        logic [7:0] m;
        case (depth)
            DEPTH_1:  m = 8'h80;
            DEPTH_2:  m = 8'hC0;
            DEPTH_4:  m = 8'hF0;
            DEPTH_8:  m = 8'hFF;
            DEPTH_16: m = 8'hFF;
            default:  m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

[rtl/bitmap_rotate_90_packed.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rotate_90_packed
// Frame store plus gather unit that returns bytes of a bitmap turned by 90
// degrees at 1, 2, 4, 8 or 16 bits per pixel.
// ----------------------------------------------------------------------------
// A write word stores one source byte. A read word makes ppb source reads,
// ppb being the source reads per destination byte (8 at 1 bpp, 4 at 2, 2
// at 4, 1 at 8 and 16); a read that is out of range or has an unused depth
// code answers on the next cycle. A new word is taken only once busy is
// low again. Throughput is bounded by the one address multiplier and the
// single frame store port, used once per source pixel through an
// address/read/pack pipe. Each read returns exactly
// one result word on o_result with o_done high for one cycle; the receiver
// cannot stall it. Writes return nothing. The frame store needs no clearing
// after reset. Configuration is taken at any time through the cfg channel,
// which is always ready, but must only change while busy is low.
// ----------------------------------------------------------------------------
module bitmap_rotate_90_packed #(
    parameter int MAX_DIM     = br90_pkg::MAX_DIM_DEF,
    parameter int FRAME_BYTES = br90_pkg::FRAME_BYTES_DEF,
    parameter int MAX_STRIDE  = br90_pkg::MAX_STRIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  br90_pkg::t_in_word                  i_item,
    output logic                                o_done,
    output br90_pkg::t_out_word                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [br90_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [br90_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import br90_pkg::*;

    localparam int MEM_AW = $clog2(FRAME_BYTES);
    localparam int ADDR_W = (MEM_AW > CALC_W) ? MEM_AW : CALC_W;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    // configuration
    logic [7:0] r_src_width, r_src_height;
    logic [8:0] r_src_stride, r_dest_stride;
    logic [2:0] r_depth_code;
    logic       r_turn_cw;

    // sequencer
    t_state      r_state, n_state;
    logic        r_wr, n_wr;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_k, n_k;
    logic [10:0] r_pbase, n_pbase;
    logic [8:0]  r_xb, n_xb;
    logic [2:0]  r_off, n_off;
    logic [7:0]  r_mask, n_mask;
    logic [1:0]  r_lg, n_lg;
    logic [7:0]  r_wdata, n_wdata;
    logic [7:0]  r_acc, n_acc;
    logic        r_done, n_done;
    t_out_word   r_result, n_result;

    // pipe
    logic              r_s1_vld, n_s1_vld, r_s1_use, n_s1_use;
    logic [7:0]        r_s1_y, n_s1_y;
    logic [2:0]        r_s1_k, n_s1_k;
    logic              r_s2_vld, n_s2_vld, r_s2_use, n_s2_use;
    logic [ADDR_W-1:0] r_s2_addr, n_s2_addr;
    logic [2:0]        r_s2_k, n_s2_k;
    logic              r_s3_vld, n_s3_vld, r_s3_use, n_s3_use;
    logic [2:0]        r_s3_k, n_s3_k;
    logic [7:0]        r_rdata;

    logic [7:0] r_mem [FRAME_BYTES];

    // saturated settings
    logic [7:0]  w_sat, h_sat;
    logic [8:0]  ss_sat, ds_sat;
    logic [7:0]  row_x;
    logic [3:0]  ppb;
    logic [1:0]  lg;
    logic        depth16;
    logic [10:0] p;
    logic [CALC_W-1:0] addr_calc;
    logic [5:0]  k_shift;
    logic [7:0]  pix;

    always_comb begin
        w_sat   = (32'(r_src_width) > MAX_DIM) ? 8'(MAX_DIM) : r_src_width;
        h_sat   = (32'(r_src_height) > MAX_DIM) ? 8'(MAX_DIM) : r_src_height;
        ss_sat  = (32'(r_src_stride) > MAX_STRIDE) ? 9'(MAX_STRIDE) : r_src_stride;
        ds_sat  = (32'(r_dest_stride) > MAX_STRIDE) ? 9'(MAX_STRIDE) : r_dest_stride;
        row_x   = r_turn_cw ? {1'b0, i_item.row} : 8'(w_sat - 8'd1 - {1'b0, i_item.row});
        ppb     = pixels_per_byte(r_depth_code);
        lg      = r_depth_code[1:0];
        depth16 = (r_depth_code == DEPTH_16);
        p       = r_pbase + 11'(r_k);
        addr_calc = CALC_W'(r_s1_y) * CALC_W'(ss_sat) + CALC_W'(r_xb);
        k_shift = 6'(r_s3_k) << r_lg;
        pix     = (8'(r_rdata << r_off) & r_mask) >> k_shift[2:0];
    end

    always_comb begin
        n_state  = r_state;
        n_wr     = r_wr;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_pbase  = r_pbase;
        n_xb     = r_xb;
        n_off    = r_off;
        n_mask   = r_mask;
        n_lg     = r_lg;
        n_wdata  = r_wdata;
        n_acc    = r_acc;
        n_done   = 1'b0;
        n_result = r_result;
        n_s1_vld = 1'b0;
        n_s1_use = 1'b0;
        n_s1_y   = r_s1_y;
        n_s1_k   = r_s1_k;
        n_s2_vld = r_s1_vld;
        n_s2_use = r_s1_use && (32'(addr_calc) < FRAME_BYTES);
        n_s2_addr = ADDR_W'(addr_calc);
        n_s2_k   = r_s1_k;
        n_s3_vld = r_s2_vld && !r_wr;
        n_s3_use = r_s2_use;
        n_s3_k   = r_s2_k;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.action == ACT_WRITE) begin
                        n_state = S_RUN;
                        n_wr    = 1'b1;
                        n_cnt   = 4'd1;
                        n_k     = 4'd0;
                        n_pbase = 11'(i_item.row);
                        n_xb    = 9'(i_item.byte_col);
                        n_wdata = i_item.data;
                    end else if (({1'b0, i_item.row} >= w_sat) ||
                                 ({1'b0, i_item.byte_col} >= ds_sat)) begin
                        n_done   = 1'b1;
                        n_result = '{out_byte: 8'd0, out_of_range: 1'b1};
                    end else if (ppb == 4'd0) begin
                        n_done   = 1'b1;
                        n_result = '{out_byte: 8'd0, out_of_range: 1'b0};
                    end else begin
                        n_state = S_RUN;
                        n_wr    = 1'b0;
                        n_cnt   = ppb;
                        n_k     = 4'd0;
                        n_acc   = 8'd0;
                        n_mask  = top_mask(r_depth_code);
                        n_lg    = lg;
                        if (depth16) begin
                            n_pbase = 11'(i_item.byte_col[7:1]);
                            n_xb    = {row_x, i_item.byte_col[0]};
                            n_off   = 3'd0;
                        end else begin
                            n_pbase = 11'(i_item.byte_col) << (2'd3 - lg);
                            n_xb    = 9'(row_x >> (2'd3 - lg));
                            n_off   = 3'((row_x[2:0] & 3'(ppb - 4'd1)) << lg);
                        end
                    end
                end
            end
            S_RUN: begin
                if (r_k != r_cnt) begin
                    n_s1_vld = 1'b1;
                    n_s1_use = r_wr || (p < 11'(h_sat));
                    n_s1_k   = r_k[2:0];
                    if (r_wr) begin
                        n_s1_y = r_pbase[7:0];
                    end else if (r_turn_cw) begin
                        n_s1_y = 8'(h_sat - 8'd1 - p[7:0]);
                    end else begin
                        n_s1_y = p[7:0];
                    end
                    n_k = r_k + 4'd1;
                end
                if (r_s3_vld && r_s3_use) begin
                    n_acc = r_acc | pix;
                end
                if ((r_k == r_cnt) && !r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                    n_state = S_IDLE;
                    if (!r_wr) begin
                        n_done   = 1'b1;
                        n_result = '{out_byte: r_acc, out_of_range: 1'b0};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_done        <= 1'b0;
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_s3_vld      <= 1'b0;
            r_k           <= 4'd0;
            r_cnt         <= 4'd0;
            r_wr          <= 1'b0;
            r_src_width   <= 8'd1;
            r_src_height  <= 8'd1;
            r_src_stride  <= 9'd1;
            r_dest_stride <= 9'd1;
            r_depth_code  <= DEPTH_1;
            r_turn_cw     <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
            r_s3_vld <= n_s3_vld;
            r_k      <= n_k;
            r_cnt    <= n_cnt;
            r_wr     <= n_wr;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH:   r_src_width   <= i_cfg_data[7:0];
                    CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_data[7:0];
                    CFG_SRC_STRIDE:  r_src_stride  <= i_cfg_data;
                    CFG_DEST_STRIDE: r_dest_stride <= i_cfg_data;
                    CFG_DEPTH_CODE:  r_depth_code  <= i_cfg_data[2:0];
                    CFG_TURN_CW:     r_turn_cw     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_pbase   <= n_pbase;
        r_xb      <= n_xb;
        r_off     <= n_off;
        r_mask    <= n_mask;
        r_lg      <= n_lg;
        r_wdata   <= n_wdata;
        r_acc     <= n_acc;
        r_result  <= n_result;
        r_s1_use  <= n_s1_use;
        r_s1_y    <= n_s1_y;
        r_s1_k    <= n_s1_k;
        r_s2_use  <= n_s2_use;
        r_s2_addr <= n_s2_addr;
        r_s2_k    <= n_s2_k;
        r_s3_use  <= n_s3_use;
        r_s3_k    <= n_s3_k;
    end

    // frame store, one port
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && r_wr && r_s2_use) begin
            r_mem[r_s2_addr[MEM_AW-1:0]] <= r_wdata;
        end
        r_rdata <= r_mem[r_s2_addr[MEM_AW-1:0]];
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && busy))
        else $error("result strobe while busy");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.action == ACT_WRITE)) |=> !o_done)
        else $error("write word produced a result");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_of_range) |-> (o_result.out_byte == 8'd0))
        else $error("out-of-range result carries data");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result without a started word");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitmap_rotate_90_packed. A directed table covers
// reset values, extreme and zero settings, saturation, unused depth codes and
// column wrap. Random phases follow, each with fresh settings, mixing source
// writes with destination reads. Source bytes that a read will gather are
// written first. Every read is checked against a table value or bench model.
// ----------------------------------------------------------------------------
module testbench;
    import br90_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 20;
    localparam int QUIET_LIMIT     = 1000;
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 84;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_in_word              word;
        bit                    typed;
        t_out_word             want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_word              i_item;
    logic                  o_done;
    t_out_word             o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [7:0] frame_img [FRAME_BYTES_DEF];
    bit         frame_set [FRAME_BYTES_DEF];
    int         set_w, set_h, set_ss, set_ds;
    logic [2:0] set_depth;
    logic       set_cw;
    t_out_word  pending_bytes [$];
    t_out_word  head_byte;
    t_plan_row  plan [$];
    int         error_count  = 0;
    int         quiet_cycles = 0;
    bit         gaps_on;

    bitmap_rotate_90_packed u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic int clip(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic int pixel_bits(input logic [2:0] depth);
        case (depth)
            DEPTH_2:  return 2;
            DEPTH_4:  return 4;
            DEPTH_8:  return 8;
            DEPTH_16: return 16;
            default:  return 1;
        endcase
    endfunction

    function automatic bit in_dest(input logic [6:0] row, input logic [7:0] col);
        return int'(row) < clip(set_w, MAX_DIM_DEF) && int'(col) < clip(set_ds, MAX_STRIDE_DEF);
    endfunction

    // location of pixel k of a destination byte; 0 for padding
    function automatic bit pixel_loc(input logic [6:0] row, input logic [7:0] col, input int k,
                                     output int addr, output int shl);
        int w, h, ss, x, p, y, lg, ppb;
        w    = clip(set_w, MAX_DIM_DEF);
        h    = clip(set_h, MAX_DIM_DEF);
        ss   = clip(set_ss, MAX_STRIDE_DEF);
        x    = set_cw ? int'(row) : w - 1 - int'(row);
        addr = 0;
        shl  = 0;
        if (set_depth == DEPTH_16) begin
            p = int'(col) / 2;
            if (k != 0 || p >= h) return 0;
            y    = set_cw ? h - 1 - p : p;
            addr = y * ss + x * 2 + int'(col[0]);
            return 1;
        end
        lg  = int'(set_depth);
        ppb = 8 >> lg;
        p   = int'(col) * ppb + k;
        if (k >= ppb || p >= h) return 0;
        y    = set_cw ? h - 1 - p : p;
        addr = y * ss + ((x << lg) >> 3);
        shl  = (x & (ppb - 1)) << lg;
        return 1;
    endfunction

    function automatic t_out_word rotated_byte(input logic [6:0] row, input logic [7:0] col);
        t_out_word res;
        int        acc, bits, addr, shl, k, px;
        res = '0;
        acc = 0;
        if (!in_dest(row, col)) begin
            res.out_of_range = 1'b1;
            return res;
        end
        if (set_depth > DEPTH_16) return res;
        bits = (set_depth == DEPTH_16) ? 8 : pixel_bits(set_depth);
        for (k = 0; k < 8; k++) begin
            if (pixel_loc(row, col, k, addr, shl)) begin
                px  = ((int'(frame_img[addr]) << shl) & 255) >> (8 - bits);
                acc = acc | (px << (8 - bits * (k + 1)));
            end
        end
        res.out_byte = acc[7:0];
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_plan_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic t_plan_row word_row(input logic act, input logic [6:0] row,
                                           input logic [7:0] col, input logic [7:0] data,
                                           input bit typed, input logic [7:0] out_byte,
                                           input logic oor);
        t_plan_row r;
        r                   = '{default: '0};
        r.word              = '{action: act, row: row, byte_col: col, data: data};
        r.typed             = typed;
        r.want.out_byte     = out_byte;
        r.want.out_of_range = oor;
        return r;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        int gap;
        int addr;
        gap = gaps_on ? gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= w;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        if (w.action == ACT_READ) begin
            pending_bytes.push_back(typed ? want : rotated_byte(w.row, w.byte_col));
        end else begin
            addr = int'(w.row) * clip(set_ss, MAX_STRIDE_DEF) + int'(w.byte_col);
            if (addr < FRAME_BYTES_DEF) begin
                frame_img[addr] = w.data;
                frame_set[addr] = 1'b1;
            end
        end
    endtask

    // fill any source byte the read will gather, then issue the read
    task automatic issue_read(input logic [6:0] row, input logic [7:0] col, input logic [7:0] data,
                              input bit typed, input t_out_word want);
        int       addr, shl, k, r, ss;
        t_in_word w;
        ss = clip(set_ss, MAX_STRIDE_DEF);
        if (in_dest(row, col) && set_depth <= DEPTH_16) begin
            for (k = 0; k < 8; k++) begin
                if (pixel_loc(row, col, k, addr, shl) && !frame_set[addr]) begin
                    w.action = ACT_WRITE;
                    w.data   = 8'($urandom_range(0, 255));
                    if (ss == 0) begin
                        w.row      = 7'($urandom_range(0, 127));
                        w.byte_col = 8'(addr);
                    end else begin
                        r          = clip(addr / ss, 127);
                        w.row      = 7'(r);
                        w.byte_col = 8'(addr - r * ss);
                    end
                    send_word(w, 1'b0, '0);
                end
            end
        end
        w = '{action: ACT_READ, row: row, byte_col: col, data: data};
        send_word(w, typed, want);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_SRC_WIDTH:   set_w     = int'(val[7:0]);
            CFG_SRC_HEIGHT:  set_h     = int'(val[7:0]);
            CFG_SRC_STRIDE:  set_ss    = int'(val[8:0]);
            CFG_DEST_STRIDE: set_ds    = int'(val[8:0]);
            CFG_DEPTH_CODE:  set_depth = val[2:0];
            CFG_TURN_CW:     set_cw    = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return MAX_DIM_DEF;
        if (r == 1) return $urandom_range(0, 511);
        if (r == 2) return 1;
        return $urandom_range(1, 16);
    endfunction

    task automatic random_settings();
        logic [2:0] depth;
        int         w, h, bits, ss, ds;
        depth = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        w     = pick_dim();
        h     = pick_dim();
        bits  = pixel_bits(depth);
        ss    = (clip(w & 255, MAX_DIM_DEF) * bits + 7) / 8 + $urandom_range(0, 2);
        ds    = (clip(h & 255, MAX_DIM_DEF) * bits + 7) / 8 + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) ss = $urandom_range(0, 511);
        if ($urandom_range(0, 7) == 0) ds = $urandom_range(0, 511);
        write_setting(CFG_SRC_WIDTH, 9'(w));
        write_setting(CFG_SRC_HEIGHT, 9'(h));
        write_setting(CFG_SRC_STRIDE, 9'(ss));
        write_setting(CFG_DEST_STRIDE, 9'(ds));
        write_setting(CFG_DEPTH_CODE, 9'(depth));
        write_setting(CFG_TURN_CW, 9'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0) write_setting(CFG_SPARE, 9'($urandom_range(0, 511)));
    endtask

    task automatic random_word();
        int       w, h, sb, db;
        t_in_word iw;
        w           = clip(set_w, MAX_DIM_DEF);
        h           = clip(set_h, MAX_DIM_DEF);
        sb          = clip((w * pixel_bits(set_depth) + 7) / 8, 256);
        db          = clip(set_ds, MAX_STRIDE_DEF);
        iw.data     = 8'($urandom_range(0, 255));
        iw.row      = 7'($urandom_range(0, 127));
        iw.byte_col = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 30) begin
            iw.action = ACT_WRITE;
            if ($urandom_range(0, 9) != 0 && h > 0 && sb > 0) begin
                iw.row      = 7'($urandom_range(0, h - 1));
                iw.byte_col = 8'($urandom_range(0, sb - 1));
            end
            send_word(iw, 1'b0, '0);
        end else begin
            if ($urandom_range(0, 9) != 0 && w > 0) iw.row = 7'($urandom_range(0, w - 1));
            if ($urandom_range(0, 9) != 0 && db > 0) iw.byte_col = 8'($urandom_range(0, db - 1));
            issue_read(iw.row, iw.byte_col, iw.data, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_bytes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word, expected none, actual byte %h oor %b",
                         $time, o_result.out_byte, o_result.out_of_range);
            end else begin
                head_byte = pending_bytes.pop_front();
                if (o_result.out_byte !== head_byte.out_byte) begin
                    error_count++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, head_byte.out_byte, o_result.out_byte);
                end
                if (o_result.out_of_range !== head_byte.out_of_range) begin
                    error_count++;
                    $display("%0t: out_of_range expected %b actual %b",
                             $time, head_byte.out_of_range, o_result.out_of_range);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        set_w       = 1;
        set_h       = 1;
        set_ss      = 1;
        set_ds      = 1;
        set_depth   = DEPTH_1;
        set_cw      = 1'b1;
        gaps_on     = 1'b1;

        // reset values, out of range rows and columns
        plan.push_back(word_row(ACT_WRITE, 7'd0, 8'd0, 8'hFF, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd0, 8'h00, 1, 8'h80, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd1, 8'd0, 8'h00, 1, 8'h00, 1'b1));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd1, 8'h00, 1, 8'h00, 1'b1));
        plan.push_back(word_row(ACT_READ, 7'd127, 8'd255, 8'hFF, 1, 8'h00, 1'b1));
        // unused depth code
        plan.push_back(cfg_row(CFG_DEPTH_CODE, 9'd7));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd0, 8'h00, 1, 8'h00, 1'b0));
        // saturating sizes, 16 bpp, counter-clockwise
        plan.push_back(cfg_row(CFG_SRC_WIDTH, 9'd200));
        plan.push_back(cfg_row(CFG_SRC_HEIGHT, 9'd128));
        plan.push_back(cfg_row(CFG_SRC_STRIDE, 9'd300));
        plan.push_back(cfg_row(CFG_DEST_STRIDE, 9'd511));
        plan.push_back(cfg_row(CFG_DEPTH_CODE, 9'(DEPTH_16)));
        plan.push_back(cfg_row(CFG_TURN_CW, 9'd0));
        plan.push_back(word_row(ACT_WRITE, 7'd127, 8'd255, 8'hA5, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_WRITE, 7'd0, 8'd1, 8'h3C, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd255, 8'h00, 1, 8'hA5, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd127, 8'd0, 8'h00, 1, 8'hFF, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd127, 8'd1, 8'h00, 1, 8'h3C, 1'b0));
        // zero source stride: every row shares one set of addresses
        plan.push_back(cfg_row(CFG_SRC_STRIDE, 9'd0));
        plan.push_back(cfg_row(CFG_DEPTH_CODE, 9'(DEPTH_8)));
        plan.push_back(cfg_row(CFG_TURN_CW, 9'd1));
        plan.push_back(cfg_row(CFG_SRC_WIDTH, 9'd4));
        plan.push_back(cfg_row(CFG_SRC_HEIGHT, 9'd2));
        plan.push_back(cfg_row(CFG_DEST_STRIDE, 9'd2));
        plan.push_back(word_row(ACT_WRITE, 7'd5, 8'd2, 8'h5A, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd2, 8'd0, 8'h00, 1, 8'h5A, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd2, 8'd1, 8'h00, 1, 8'h5A, 1'b0));
        // zero height, zero width, zero dest stride
        plan.push_back(cfg_row(CFG_SRC_HEIGHT, 9'd0));
        plan.push_back(word_row(ACT_READ, 7'd3, 8'd1, 8'h00, 1, 8'h00, 1'b0));
        plan.push_back(cfg_row(CFG_SRC_WIDTH, 9'd0));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd0, 8'h00, 1, 8'h00, 1'b1));
        plan.push_back(cfg_row(CFG_SRC_WIDTH, 9'd4));
        plan.push_back(cfg_row(CFG_SRC_HEIGHT, 9'd3));
        plan.push_back(cfg_row(CFG_DEST_STRIDE, 9'd0));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd0, 8'h00, 1, 8'h00, 1'b1));
        // 4 bpp with column wrapping past the stride, padding in last byte
        plan.push_back(cfg_row(CFG_DEST_STRIDE, 9'd2));
        plan.push_back(cfg_row(CFG_SRC_STRIDE, 9'd2));
        plan.push_back(cfg_row(CFG_DEPTH_CODE, 9'(DEPTH_4)));
        plan.push_back(cfg_row(CFG_TURN_CW, 9'd0));
        plan.push_back(word_row(ACT_WRITE, 7'd0, 8'd3, 8'hC7, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd1, 8'd0, 8'h00, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd1, 8'h00, 0, 8'h00, 1'b0));
        // 2 bpp and 1 bpp clockwise
        plan.push_back(cfg_row(CFG_DEPTH_CODE, 9'(DEPTH_2)));
        plan.push_back(cfg_row(CFG_SRC_WIDTH, 9'd8));
        plan.push_back(cfg_row(CFG_SRC_HEIGHT, 9'd5));
        plan.push_back(cfg_row(CFG_TURN_CW, 9'd1));
        plan.push_back(word_row(ACT_READ, 7'd7, 8'd1, 8'h00, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd3, 8'd0, 8'h00, 0, 8'h00, 1'b0));
        plan.push_back(cfg_row(CFG_DEPTH_CODE, 9'(DEPTH_1)));
        plan.push_back(cfg_row(CFG_SRC_HEIGHT, 9'd9));
        plan.push_back(cfg_row(CFG_SPARE, 9'd511));
        plan.push_back(word_row(ACT_READ, 7'd5, 8'd1, 8'h00, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_WRITE, 7'd1, 8'd0, 8'h00, 0, 8'h00, 1'b0));
        plan.push_back(word_row(ACT_READ, 7'd0, 8'd1, 8'h00, 0, 8'h00, 1'b0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain();
                write_setting(plan[i].idx, plan[i].val);
            end else if (plan[i].word.action == ACT_READ) begin
                issue_read(plan[i].word.row, plan[i].word.byte_col, plan[i].word.data,
                           plan[i].typed, plan[i].want);
            end else begin
                send_word(plan[i].word, 1'b0, '0);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            random_settings();
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < WORDS_PER_PHASE; n++) random_word();
        end

        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
